FILE: hdl/jtl_pkg.sv
package jtl_pkg;

    localparam int CHAR_BITS = 8;
    localparam int OUT_NUM_BITS = 32;

    typedef enum logic [3:0]
    {
        MODE_IDLE = 4'b0001,
        MODE_NUM  = 4'b0010,
        MODE_STR  = 4'b0100,
        MODE_KEY  = 4'b1000
    } lex_mode_t;

    typedef enum logic [3:0]
    {
        TK_BRACKET = 4'd0,
        TK_COLON   = 4'd1,
        TK_COMMA   = 4'd2,
        TK_SBYTE   = 4'd3,
        TK_SEND    = 4'd4,
        TK_NUMBER  = 4'd5,
        TK_BOOL    = 4'd6,
        TK_NULL    = 4'd7,
        TK_NONE    = 4'd8
    } tok_kind_t;

    typedef enum logic [1:0]
    {
        KW_NULL  = 2'd0,
        KW_TRUE  = 2'd1,
        KW_FALSE = 2'd2,
        KW_SPARE = 2'd3
    } kw_pick_t;

    localparam logic [CHAR_BITS-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_BITS-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_BITS-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_BITS-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_BITS-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_BITS-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
    localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_BITS-1:0] CH_N      = 8'h6E;
    localparam logic [CHAR_BITS-1:0] CH_T      = 8'h74;
    localparam logic [CHAR_BITS-1:0] CH_F      = 8'h66;

    typedef struct packed
    {
        tok_kind_t                kind;
        logic [CHAR_BITS-1:0]     char_value;
        logic [OUT_NUM_BITS-1:0]  number_value;
        logic                     bool_value;
    } token_t;

    // one queue entry: every token caused by one input byte
    typedef struct packed
    {
        token_t tok0;
        logic   has_two;
        token_t tok1;
    } entry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } fifo_stat_t;

    typedef struct packed
    {
        logic      emit;
        token_t    tok;
        lex_mode_t mode;
        kw_pick_t  pick;
    } idle_res_t;

    function automatic logic is_digit(input logic [CHAR_BITS-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    function automatic token_t make_tok(input tok_kind_t k, input logic [CHAR_BITS-1:0] ch);
        token_t t;
        t = '0;
        t.kind = k;
        t.char_value = ch;
        return t;
    endfunction

    // classify one byte with the lexer idle
    function automatic idle_res_t idle_decode(input logic [CHAR_BITS-1:0] b);
        idle_res_t r;
        r.emit = 1'b0;
        r.tok = make_tok(TK_NONE, '0);
        r.mode = MODE_IDLE;
        r.pick = KW_NULL;
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
        begin
            r.emit = 1'b0;
        end
        else if (b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK || b == CH_RBRACK)
        begin
            r.emit = 1'b1;
            r.tok = make_tok(TK_BRACKET, b);
        end
        else if (b == CH_COLON)
        begin
            r.emit = 1'b1;
            r.tok = make_tok(TK_COLON, b);
        end
        else if (b == CH_COMMA)
        begin
            r.emit = 1'b1;
            r.tok = make_tok(TK_COMMA, b);
        end
        else if (is_digit(b))
        begin
            r.mode = MODE_NUM;
        end
        else if (b == CH_QUOTE)
        begin
            r.mode = MODE_STR;
        end
        else if (b == CH_N || b == CH_T || b == CH_F)
        begin
            r.mode = MODE_KEY;
            r.pick = (b == CH_N) ? KW_NULL : (b == CH_T) ? KW_TRUE : KW_FALSE;
        end
        else
        begin
            r.emit = 1'b1;
        end
        return r;
    endfunction

    function automatic logic [2:0] kw_len(input kw_pick_t p);
        return (p == KW_FALSE) ? 3'd5 : 3'd4;
    endfunction

    function automatic logic [CHAR_BITS-1:0] kw_char(input kw_pick_t p, input logic [2:0] pos);
        logic [CHAR_BITS-1:0] c;
        c = '0;
        case (p)
            KW_TRUE:
            begin
                case (pos)
                    3'd1: c = 8'h72;
                    3'd2: c = 8'h75;
                    3'd3: c = 8'h65;
                    default: c = '0;
                endcase
            end
            KW_FALSE:
            begin
                case (pos)
                    3'd1: c = 8'h61;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h73;
                    3'd4: c = 8'h65;
                    default: c = '0;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd1: c = 8'h75;
                    3'd2: c = 8'h6C;
                    3'd3: c = 8'h6C;
                    default: c = '0;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

FILE: hdl/jtl_front.sv
module jtl_front #(
    parameter int NUMBER_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  in_kind,
    input  logic [7:0]            in_byte,
    input  jtl_pkg::fifo_stat_t   q_stat,
    output logic                  push,
    output jtl_pkg::entry_t       push_entry
);
    import jtl_pkg::*;

    localparam int WIDE_BITS = NUMBER_BITS + 4;

    lex_mode_t              mode_reg, mode_next;
    logic [NUMBER_BITS-1:0] acc_reg, acc_next;
    kw_pick_t               pick_reg, pick_next;
    logic [2:0]             pos_reg, pos_next;

    logic      accept;
    idle_res_t ir;
    kw_pick_t  pick_eff;
    logic [WIDE_BITS-1:0] acc_w;
    logic [WIDE_BITS-1:0] acc_mac;
    token_t    num_tok;
    token_t    kw_tok;
    entry_t    ent;
    logic      have_tok;

    assign in_ready = !q_stat.full;
    assign accept = in_valid && in_ready;

    always_comb
    begin
        ir = idle_decode(in_byte);
        pick_eff = (pick_reg == KW_SPARE) ? KW_NULL : pick_reg;
        acc_w = WIDE_BITS'(acc_reg);
        // acc * 10 + digit, never above 16 * 2^NUMBER_BITS
        acc_mac = (acc_w << 3) + (acc_w << 1) + WIDE_BITS'(in_byte[3:0]);

        num_tok = make_tok(TK_NUMBER, '0);
        num_tok.number_value = OUT_NUM_BITS'(acc_reg);
        kw_tok = make_tok((pick_eff == KW_NULL) ? TK_NULL : TK_BOOL, '0);
        kw_tok.bool_value = (pick_eff == KW_TRUE);

        mode_next = mode_reg;
        acc_next = acc_reg;
        pick_next = pick_reg;
        pos_next = pos_reg;
        ent = '0;
        have_tok = 1'b0;

        if (in_kind)
        begin
            case (mode_reg)
                MODE_NUM:
                begin
                    have_tok = 1'b1;
                    ent.tok0 = num_tok;
                end
                MODE_STR:
                begin
                    have_tok = 1'b1;
                    ent.tok0 = make_tok(TK_SEND, '0);
                end
                MODE_KEY:
                begin
                    have_tok = 1'b1;
                    ent.tok0 = make_tok(TK_NONE, '0);
                end
                default:
                begin
                    have_tok = 1'b0;
                end
            endcase
            mode_next = MODE_IDLE;
            acc_next = '0;
            pick_next = KW_NULL;
            pos_next = '0;
        end
        else
        begin
            case (mode_reg)
                MODE_NUM:
                begin
                    if (is_digit(in_byte))
                    begin
                        if (acc_mac[WIDE_BITS-1:NUMBER_BITS] != 4'd0)
                            acc_next = '1;
                        else
                            acc_next = acc_mac[NUMBER_BITS-1:0];
                    end
                    else
                    begin
                        // number closes, then the byte is lexed from idle
                        have_tok = 1'b1;
                        ent.tok0 = num_tok;
                        ent.has_two = ir.emit;
                        ent.tok1 = ir.tok;
                        mode_next = ir.mode;
                        acc_next = '0;
                        pick_next = ir.pick;
                        pos_next = (ir.mode == MODE_KEY) ? 3'd1 : 3'd0;
                    end
                end
                MODE_STR:
                begin
                    have_tok = 1'b1;
                    if (in_byte == CH_QUOTE)
                    begin
                        ent.tok0 = make_tok(TK_SEND, '0);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        ent.tok0 = make_tok(TK_SBYTE, in_byte);
                    end
                end
                MODE_KEY:
                begin
                    if (pos_reg < kw_len(pick_eff) && in_byte == kw_char(pick_eff, pos_reg))
                    begin
                        pos_next = pos_reg + 3'd1;
                        if (pos_next == kw_len(pick_eff))
                        begin
                            have_tok = 1'b1;
                            ent.tok0 = kw_tok;
                            mode_next = MODE_IDLE;
                            pick_next = KW_NULL;
                            pos_next = '0;
                        end
                    end
                    else
                    begin
                        have_tok = 1'b1;
                        ent.tok0 = make_tok(TK_NONE, '0);
                        ent.has_two = ir.emit;
                        ent.tok1 = ir.tok;
                        mode_next = ir.mode;
                        acc_next = (ir.mode == MODE_NUM) ? NUMBER_BITS'(in_byte[3:0]) : '0;
                        pick_next = ir.pick;
                        pos_next = (ir.mode == MODE_KEY) ? 3'd1 : 3'd0;
                    end
                end
                default:
                begin
                    have_tok = ir.emit;
                    ent.tok0 = ir.tok;
                    mode_next = ir.mode;
                    acc_next = (ir.mode == MODE_NUM) ? NUMBER_BITS'(in_byte[3:0]) : '0;
                    pick_next = ir.pick;
                    pos_next = (ir.mode == MODE_KEY) ? 3'd1 : 3'd0;
                end
            endcase
        end
    end

    assign push = accept && have_tok;
    assign push_entry = ent;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_IDLE;
            acc_reg <= '0;
            pick_reg <= KW_NULL;
            pos_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg <= mode_next;
            acc_reg <= acc_next;
            pick_reg <= pick_next;
            pos_reg <= pos_next;
        end
    end

endmodule

FILE: hdl/jtl_queue.sv
module jtl_queue #(
    parameter int DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  jtl_pkg::entry_t      push_entry,
    input  logic                 pop,
    output jtl_pkg::entry_t      pop_entry,
    output jtl_pkg::fifo_stat_t  stat
);
    import jtl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push = push && !stat.full;
    assign do_pop = pop && !stat.empty;
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (!do_push && do_pop)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

FILE: hdl/jtl_back.sv
module jtl_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  jtl_pkg::fifo_stat_t  q_stat,
    input  jtl_pkg::entry_t      q_entry,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output jtl_pkg::token_t      out_tok,
    output logic                 out_last
);
    import jtl_pkg::*;

    logic   valid_reg, valid_next;
    logic   pend_reg, pend_next;
    token_t tok_reg, tok_next;
    token_t pend_tok_reg, pend_tok_next;
    logic   last_reg, last_next;
    logic   load;

    assign load = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        pend_next = pend_reg;
        tok_next = tok_reg;
        pend_tok_next = pend_tok_reg;
        last_next = last_reg;
        pop = 1'b0;
        if (load)
        begin
            if (pend_reg)
            begin
                // second token of a two-token entry
                tok_next = pend_tok_reg;
                last_next = 1'b1;
                valid_next = 1'b1;
                pend_next = 1'b0;
            end
            else if (!q_stat.empty)
            begin
                pop = 1'b1;
                tok_next = q_entry.tok0;
                last_next = !q_entry.has_two;
                valid_next = 1'b1;
                pend_next = q_entry.has_two;
                pend_tok_next = q_entry.tok1;
            end
            else
            begin
                valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
        pend_tok_reg <= pend_tok_next;
        last_reg <= last_next;
    end

    assign out_valid = valid_reg;
    assign out_tok = tok_reg;
    assign out_last = last_reg;

endmodule

FILE: hdl/json_token_lexer.sv
// channel  | dir | tdata (low bit up)                            | tuser       | tlast
// s_*      | in  | text_byte[7:0]                                | kind        | -
// m_*      | out | char_value[7:0], number_value[39:8],          | token_kind  | last
//          |     | bool_value[40], zero pad [47:41]              |             |
//
// One byte is accepted per cycle while the token queue has room; the lexer state update
// (including the acc*10+digit step) completes in that cycle. The output drains one token
// per cycle while m_tready is high; a byte that yields two tokens sends them in order,
// with tlast on the second. A token passes through the queue and the output register
// before it appears on m_*. rst_n is asynchronous and empties the queue and lexer state.
// Output stalls back up through the queue of QUEUE_DEPTH entries before s_tready drops.
module json_token_lexer #(
    parameter int NUMBER_BITS = 32,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte[7:0]
    input  logic [0:0]  s_tuser,   // kind[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // char_value[7:0], number_value[39:8], bool_value[40]
    output logic [3:0]  m_tuser,   // token_kind[3:0]
    output logic        m_tlast
);
    import jtl_pkg::*;

    logic       push;
    entry_t     push_entry;
    logic       pop;
    entry_t     pop_entry;
    fifo_stat_t q_stat;
    token_t     out_tok;

    jtl_front #(
        .NUMBER_BITS(NUMBER_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser[0]),
        .in_byte    (s_tdata),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    jtl_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .stat       (q_stat)
    );

    jtl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_entry   (pop_entry),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_tok   (out_tok),
        .out_last  (m_tlast)
    );

    assign m_tdata = {7'b0, out_tok.bool_value, out_tok.number_value, out_tok.char_value};
    assign m_tuser = out_tok.kind;

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import jtl_pkg::*;

    localparam logic KIND_TEXT = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int NUMBER_BITS = 32;
    localparam longint unsigned NUMBER_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - NUMBER_BITS);

    typedef struct packed
    {
        logic       kind;
        logic [7:0] text_byte;
    } text_item_t;

    typedef struct packed
    {
        tok_kind_t   kind;
        logic [7:0]  char_value;
        logic [31:0] number_value;
        logic        bool_value;
        logic        last;
    } lexed_token_t;

    class lexer_scoreboard;
        lex_mode_t       mode;
        longint unsigned accum;
        kw_pick_t        pick;
        logic [2:0]      pos;
        string           kw_word[3];
        lexed_token_t    batch[$];
        lexed_token_t    tokens_due[$];
        int              errors;
        int              items_seen;
        int              end_marks;
        int              tokens_checked;
        int              saturations;
        int              kind_seen[9];

        function new();
            kw_word[0] = "null";
            kw_word[1] = "true";
            kw_word[2] = "false";
            errors = 0;
            items_seen = 0;
            end_marks = 0;
            tokens_checked = 0;
            saturations = 0;
            foreach (kind_seen[k])
                kind_seen[k] = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode = MODE_IDLE;
            accum = 0;
            pick = KW_NULL;
            pos = 3'd0;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        function void put(tok_kind_t k, logic [7:0] ch, logic [31:0] num, logic bv);
            lexed_token_t t;
            t.kind = k;
            t.char_value = ch;
            t.number_value = num;
            t.bool_value = bv;
            t.last = 1'b0;
            batch.push_back(t);
        endfunction

        function void lex_idle(logic [7:0] b);
            if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
                return;
            if (b == CH_LBRACE || b == CH_RBRACE || b == CH_LBRACK || b == CH_RBRACK)
                put(TK_BRACKET, b, 32'd0, 1'b0);
            else if (b == CH_COLON)
                put(TK_COLON, b, 32'd0, 1'b0);
            else if (b == CH_COMMA)
                put(TK_COMMA, b, 32'd0, 1'b0);
            else if (b >= CH_ZERO && b <= CH_NINE)
            begin
                mode = MODE_NUM;
                accum = longint'(b - CH_ZERO);
            end
            else if (b == CH_QUOTE)
                mode = MODE_STR;
            else if (b == CH_N || b == CH_T || b == CH_F)
            begin
                mode = MODE_KEY;
                pick = (b == CH_N) ? KW_NULL : (b == CH_T) ? KW_TRUE : KW_FALSE;
                pos = 3'd1;
            end
            else
                put(TK_NONE, 8'h00, 32'd0, 1'b0);
        endfunction

        // predicts every token caused by one accepted input transaction
        function void note_text_item(logic k, logic [7:0] b);
            longint unsigned d;
            string           word;
            logic [7:0]      want;
            batch.delete();
            items_seen++;
            if (k == KIND_END)
            begin
                end_marks++;
                case (mode)
                    MODE_NUM: put(TK_NUMBER, 8'h00, accum[31:0], 1'b0);
                    MODE_STR: put(TK_SEND, 8'h00, 32'd0, 1'b0);
                    MODE_KEY: put(TK_NONE, 8'h00, 32'd0, 1'b0);
                    default: ;
                endcase
                clear_state();
            end
            else if (mode == MODE_NUM)
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    d = longint'(b - CH_ZERO);
                    if (accum > (NUMBER_MAX - d) / 10)
                    begin
                        accum = NUMBER_MAX;
                        saturations++;
                    end
                    else
                        accum = accum * 10 + d;
                end
                else
                begin
                    put(TK_NUMBER, 8'h00, accum[31:0], 1'b0);
                    clear_state();
                    lex_idle(b);
                end
            end
            else if (mode == MODE_STR)
            begin
                if (b == CH_QUOTE)
                begin
                    put(TK_SEND, 8'h00, 32'd0, 1'b0);
                    mode = MODE_IDLE;
                end
                else
                    put(TK_SBYTE, b, 32'd0, 1'b0);
            end
            else if (mode == MODE_KEY)
            begin
                word = kw_word[int'(pick)];
                want = word[int'(pos)];
                if (b == want)
                begin
                    pos = pos + 3'd1;
                    if (int'(pos) == word.len())
                    begin
                        if (pick == KW_NULL)
                            put(TK_NULL, 8'h00, 32'd0, 1'b0);
                        else
                            put(TK_BOOL, 8'h00, 32'd0, pick == KW_TRUE);
                        clear_state();
                    end
                end
                else
                begin
                    // broken keyword: none token, then the byte restarts from idle
                    put(TK_NONE, 8'h00, 32'd0, 1'b0);
                    clear_state();
                    lex_idle(b);
                end
            end
            else
                lex_idle(b);
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[i])
                tokens_due.push_back(batch[i]);
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_token(logic [3:0] tuser, logic [47:0] tdata, logic tlast);
            lexed_token_t e;
            if (tokens_due.size() == 0)
            begin
                report($sformatf("token kind %0d with nothing expected", tuser));
                return;
            end
            e = tokens_due.pop_front();
            tokens_checked++;
            kind_seen[int'(e.kind)]++;
            if (tuser !== e.kind)
                report($sformatf("token %0d kind %0d, want %0d", tokens_checked, tuser,
                                 e.kind));
            if (tdata[7:0] !== e.char_value)
                report($sformatf("token %0d char 0x%02h, want 0x%02h", tokens_checked,
                                 tdata[7:0], e.char_value));
            if (tdata[39:8] !== e.number_value)
                report($sformatf("token %0d number %0d, want %0d", tokens_checked,
                                 tdata[39:8], e.number_value));
            if (tdata[40] !== e.bool_value)
                report($sformatf("token %0d bool %b, want %b", tokens_checked, tdata[40],
                                 e.bool_value));
            if (tlast !== e.last)
                report($sformatf("token %0d last %b, want %b", tokens_checked, tlast,
                                 e.last));
        endtask
    endclass

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 1770;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_AT = 1000;
    localparam int STEADY_FROM = 1200;
    localparam int STEADY_TO = 1500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic [0:0]  s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [3:0]  m_tuser;
    logic        m_tlast;

    lexer_scoreboard sb = new();
    text_item_t      text_q[$];
    bit              hold_req = 1'b0;
    bit              steady = 1'b0;
    int              cycle_count = 0;

    json_token_lexer #(
        .NUMBER_BITS(NUMBER_BITS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic add_item(logic k, logic [7:0] b);
        text_item_t t;
        t.kind = k;
        t.text_byte = b;
        text_q.push_back(t);
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_item(KIND_TEXT, s[i]);
    endtask

    task automatic add_digits(int n);
        for (int i = 0; i < n; i++)
            add_item(KIND_TEXT, CH_ZERO + 8'($urandom_range(9)));
    endtask

    // one random JSON-like fragment; mostly well formed, some noise
    task automatic add_fragment();
        string      words[3];
        string      w;
        string      punct;
        logic [7:0] b;
        int         r;
        int         n;
        words[0] = "null";
        words[1] = "true";
        words[2] = "false";
        punct = "{}[]:,";
        r = $urandom_range(99);
        if (r < 15)
        begin
            n = $urandom_range(9);
            if (n == 0)
                add_text("4294967295");
            else if (n == 1)
            begin
                add_text("4294967296");
                add_digits($urandom_range(2));
            end
            else if (n == 2)
                add_digits($urandom_range(11, 14));
            else
                add_digits($urandom_range(1, 8));
        end
        else if (r < 35)
        begin
            add_item(KIND_TEXT, CH_QUOTE);
            n = $urandom_range(8);
            for (int i = 0; i < n; i++)
            begin
                b = 8'($urandom_range(255));
                add_item(KIND_TEXT, (b == CH_QUOTE) ? 8'h00 : b);
            end
            if ($urandom_range(9) != 0)
                add_item(KIND_TEXT, CH_QUOTE);
        end
        else if (r < 50)
            add_text(words[$urandom_range(2)]);
        else if (r < 58)
        begin
            w = words[$urandom_range(2)];
            n = $urandom_range(1, w.len() - 1);
            add_text(w.substr(0, n - 1));
            add_item(KIND_TEXT, 8'($urandom_range(255)));
        end
        else if (r < 80)
            add_item(KIND_TEXT, punct[$urandom_range(5)]);
        else if (r < 90)
        begin
            n = $urandom_range(5);
            add_item(KIND_TEXT, (n == 5) ? CH_SPACE : CH_TAB + 8'(n));
        end
        else if (r < 97)
            add_item(KIND_TEXT, 8'($urandom_range(255)));
        else
            add_item(KIND_END, 8'($urandom_range(255)));
    endtask

    task automatic build_text();
        int goal;
        add_text("[]{}:, ");
        add_item(KIND_TEXT, CH_QUOTE);
        add_item(KIND_TEXT, 8'h00);
        add_item(KIND_TEXT, 8'hFF);
        add_item(KIND_TEXT, CH_QUOTE);
        add_text("tx");
        add_text("true");
        add_text("5]");
        add_text("8");
        add_item(KIND_END, 8'hFF);
        add_item(KIND_TEXT, CH_QUOTE);
        add_item(KIND_END, 8'h00);
        add_text("n");
        add_item(KIND_END, 8'h55);
        add_item(KIND_TEXT, 8'h80);
        goal = text_q.size() + RANDOM_ITEMS;
        while (text_q.size() < goal)
            add_fragment();
    endtask

    task automatic drive_text();
        int i;
        bit hold_armed;
        bit drained;
        i = 0;
        hold_armed = 1'b0;
        drained = 1'b0;
        while (i < text_q.size())
        begin
            steady = (i >= STEADY_FROM && i < STEADY_TO);
            if (i == HOLD_AT && !hold_armed)
            begin
                hold_req = 1'b1;
                hold_armed = 1'b1;
            end
            if (i == DRAIN_AT && !drained)
            begin
                // let every expected token out before going on
                drained = 1'b1;
                s_tvalid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0)
                    @(posedge clk);
            end
            else if (!steady && $urandom_range(99) < 34)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tuser <= text_q[i].kind;
                s_tdata <= text_q[i].text_byte;
                @(posedge clk);
                while (!s_tready)
                    @(posedge clk);
                sb.note_text_item(text_q[i].kind, text_q[i].text_byte);
                i++;
            end
        end
        s_tvalid <= 1'b0;
        steady = 1'b0;
    endtask

    // sink side: random stalls, one long hold-off to back up the queue
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                for (int h = 0; h < HOLD_CYCLES; h++)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_token(m_tuser, m_tdata, m_tlast);
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("cycle limit reached, %0d tokens outstanding", sb.pending());
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        build_text();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        drive_text();
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d expected tokens never arrived", sb.pending()));
        $display("%0d input transactions (%0d end-of-text), %0d tokens, %0d saturating digits",
                 sb.items_seen, sb.end_marks, sb.tokens_checked, sb.saturations);
        $display(
            "kinds brk %0d col %0d com %0d sb %0d se %0d num %0d bool %0d null %0d none %0d",
            sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
            sb.kind_seen[4], sb.kind_seen[5], sb.kind_seen[6], sb.kind_seen[7],
            sb.kind_seen[8]);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/jtl_pkg.sv
hdl/jtl_front.sv
hdl/jtl_queue.sv
hdl/jtl_back.sv
hdl/json_token_lexer.sv
tb/testbench.sv
